// ===== rtl/positional_insert_delete_array_top_assert.svh =====
// Assertion macros used by the checker of this block.
`ifndef POSITIONAL_INSERT_DELETE_ARRAY_TOP_ASSERT_SVH
`define POSITIONAL_INSERT_DELETE_ARRAY_TOP_ASSERT_SVH

// The consequent holds in the same cycle as the antecedent.
`define PIDA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define PIDA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/pida_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package pida_pkg;

    localparam int DEPTH   = 64;
    localparam int IDX_W   = $clog2(DEPTH);
    localparam int COUNT_W = $clog2(DEPTH + 1);
    localparam int POS_W   = 7;
    localparam int CMP_W   = (POS_W > COUNT_W) ? POS_W : COUNT_W;

    localparam logic [1:0] ACT_INSERT = 2'd0;
    localparam logic [1:0] ACT_DELETE = 2'd1;
    localparam logic [1:0] ACT_READ   = 2'd2;

    localparam logic [1:0] STAT_OK     = 2'd0;
    localparam logic [1:0] STAT_FULL   = 2'd1;
    localparam logic [1:0] STAT_EMPTY  = 2'd2;
    localparam logic [1:0] STAT_BADPOS = 2'd3;

    typedef struct packed {
        logic [1:0]        action;
        logic [POS_W-1:0]  position;
        logic signed [31:0] value;
    } t_in_word;

    typedef struct packed {
        logic [1:0]          status;
        logic signed [31:0]  element;
        logic                last;
        logic [COUNT_W-1:0]  entries;
    } t_out_word;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_DELETE,
        CELL_ROTATE
    } t_cell_op;

    typedef struct packed {
        t_cell_op         op;
        logic [IDX_W-1:0] pos;
    } t_cell_ctl;

    typedef enum logic {
        ST_IDLE,
        ST_READ
    } t_state;

endpackage

`default_nettype wire

// ===== rtl/positional_insert_delete_array_top.sv =====
// Insert, delete and errors: one cycle from accepted word to registered result.
// Read-out: first entry two cycles after acceptance, then one entry per cycle
// while the output is not stalled, as the chain of cells rotates by one place.
// The next word is accepted only once the read-out's last entry is registered.
// Reset empties the array; cell contents are not cleared and are never read
// before they are written.
`timescale 1ns / 1ps
`default_nettype none

module positional_insert_delete_array_top (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    output logic                 o_in_stall,
    input  pida_pkg::t_in_word   i_in_word,
    output logic                 o_out_valid,
    input  wire                  i_out_stall,
    output pida_pkg::t_out_word  o_out_word
);

    localparam int DEPTH   = pida_pkg::DEPTH;
    localparam int IDX_W   = pida_pkg::IDX_W;
    localparam int COUNT_W = pida_pkg::COUNT_W;
    localparam int CMP_W   = pida_pkg::CMP_W;

    pida_pkg::t_state    r_state, n_state;
    logic [COUNT_W-1:0]  r_count, n_count;
    logic [IDX_W-1:0]    r_rd_idx, n_rd_idx;
    logic                r_out_valid, n_out_valid;
    pida_pkg::t_out_word r_out, n_out;

    pida_pkg::t_cell_ctl w_ctl;
    logic signed [31:0]  w_cell_data [DEPTH];
    logic                w_out_free;
    logic                w_accept;
    logic                w_rd_last;

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != pida_pkg::ST_IDLE) || !w_out_free;
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_rd_last  = (r_rd_idx == IDX_W'(r_count - 1'b1));

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            logic signed [31:0] w_left;
            logic signed [31:0] w_right;
            if (g == 0) begin : g_first
                assign w_left = i_in_word.value;
            end else begin : g_inner_l
                assign w_left = w_cell_data[g-1];
            end
            if (g == DEPTH - 1) begin : g_final
                assign w_right = w_cell_data[g];
            end else begin : g_inner_r
                assign w_right = w_cell_data[g+1];
            end
            pida_cell u_cell (
                .i_clk   (i_clk),
                .i_index (IDX_W'(g)),
                .i_ctl   (w_ctl),
                .i_left  (w_left),
                .i_right (w_right),
                .i_head  (w_cell_data[0]),
                .i_value (i_in_word.value),
                .o_data  (w_cell_data[g])
            );
        end
    endgenerate

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_rd_idx    = r_rd_idx;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        w_ctl.op    = pida_pkg::CELL_HOLD;
        w_ctl.pos   = IDX_W'(i_in_word.position);

        case (r_state)
            pida_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_out_valid   = 1'b1;
                    n_out.status  = pida_pkg::STAT_OK;
                    n_out.element = '0;
                    n_out.last    = 1'b1;
                    n_out.entries = r_count;
                    case (i_in_word.action)
                        pida_pkg::ACT_INSERT: begin
                            if (r_count == COUNT_W'(DEPTH)) begin
                                n_out.status = pida_pkg::STAT_FULL;
                            end else if (CMP_W'(i_in_word.position) > CMP_W'(r_count)) begin
                                n_out.status = pida_pkg::STAT_BADPOS;
                            end else begin
                                w_ctl.op      = pida_pkg::CELL_INSERT;
                                n_count       = r_count + 1'b1;
                                n_out.entries = r_count + 1'b1;
                            end
                        end
                        pida_pkg::ACT_DELETE: begin
                            if (r_count == '0) begin
                                n_out.status = pida_pkg::STAT_EMPTY;
                            end else if (CMP_W'(i_in_word.position) >= CMP_W'(r_count)) begin
                                n_out.status = pida_pkg::STAT_BADPOS;
                            end else begin
                                w_ctl.op      = pida_pkg::CELL_DELETE;
                                n_count       = r_count - 1'b1;
                                n_out.entries = r_count - 1'b1;
                            end
                        end
                        pida_pkg::ACT_READ: begin
                            if (r_count == '0) begin
                                n_out.status = pida_pkg::STAT_EMPTY;
                            end else begin
                                // The result words come from the read-out state.
                                n_out_valid = 1'b0;
                                n_state     = pida_pkg::ST_READ;
                                n_rd_idx    = '0;
                            end
                        end
                        default: begin
                            n_out.status = pida_pkg::STAT_BADPOS;
                        end
                    endcase
                end
            end
            pida_pkg::ST_READ: begin
                if (w_out_free) begin
                    n_out_valid   = 1'b1;
                    n_out.status  = pida_pkg::STAT_OK;
                    n_out.element = w_cell_data[0];
                    n_out.last    = w_rd_last;
                    n_out.entries = r_count;
                    w_ctl.op      = pida_pkg::CELL_ROTATE;
                    w_ctl.pos     = IDX_W'(r_count - 1'b1);
                    n_rd_idx      = r_rd_idx + 1'b1;
                    if (w_rd_last) begin
                        n_state = pida_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = pida_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pida_pkg::ST_IDLE;
            r_count     <= '0;
            r_rd_idx    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_rd_idx    <= n_rd_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

endmodule

`default_nettype wire

// ===== rtl/pida_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pida_cell (
    input  wire                          i_clk,
    input  wire [pida_pkg::IDX_W-1:0]    i_index,
    input  pida_pkg::t_cell_ctl          i_ctl,
    input  wire signed [31:0]            i_left,
    input  wire signed [31:0]            i_right,
    input  wire signed [31:0]            i_head,
    input  wire signed [31:0]            i_value,
    output logic signed [31:0]           o_data
);

    logic signed [31:0] r_data;
    logic signed [31:0] n_data;

    always_comb begin
        n_data = r_data;
        case (i_ctl.op)
            pida_pkg::CELL_INSERT: begin
                if (i_index > i_ctl.pos) begin
                    n_data = i_left;
                end else if (i_index == i_ctl.pos) begin
                    n_data = i_value;
                end
            end
            pida_pkg::CELL_DELETE: begin
                if (i_index >= i_ctl.pos) begin
                    n_data = i_right;
                end
            end
            // Rotation over the live entries: the last live cell takes the head.
            pida_pkg::CELL_ROTATE: begin
                if (i_index < i_ctl.pos) begin
                    n_data = i_right;
                end else if (i_index == i_ctl.pos) begin
                    n_data = i_head;
                end
            end
            default: begin
                n_data = r_data;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

`default_nettype wire

// ===== rtl/pida_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

`include "positional_insert_delete_array_top_assert.svh"

module pida_checker (
    input wire                  i_clk,
    input wire                  i_rst_n,
    input wire                  i_in_valid,
    input wire                  o_in_stall,
    input pida_pkg::t_in_word   i_in_word,
    input wire                  o_out_valid,
    input wire                  i_out_stall,
    input pida_pkg::t_out_word  o_out_word
);

    `PIDA_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_word), "stalled result word changed")

    `PIDA_ASSERT_NOW(a_err_single, o_out_valid && (o_out_word.status != pida_pkg::STAT_OK), o_out_word.last && (o_out_word.element == 0), "error result is not a single word")

    `PIDA_ASSERT_NOW(a_empty_count, o_out_valid && (o_out_word.status == pida_pkg::STAT_EMPTY), o_out_word.entries == 0, "empty status with live entries")

    `PIDA_ASSERT_NOW(a_count_range, o_out_valid, o_out_word.entries <= pida_pkg::COUNT_W'(pida_pkg::DEPTH), "entry count beyond depth")

    `PIDA_ASSERT_NEXT(a_single_result, i_in_valid && !o_in_stall && (i_in_word.action != pida_pkg::ACT_READ), o_out_valid && o_out_word.last, "result word missing after accepted word")

endmodule

bind positional_insert_delete_array_top pida_checker u_pida_checker (.*);

`default_nettype wire
